### sv/mac_learning_table_with_aging_unit_macros.svh
// Assertion macros for the address table block.
// Included by the RTL file that carries the concurrent checks (mlta_back); no other dependencies.
`ifndef MAC_LEARNING_TABLE_WITH_AGING_UNIT_MACROS_SVH
`define MAC_LEARNING_TABLE_WITH_AGING_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MLTA_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mlta assertion failed");
`define MLTA_ASSERT(lbl, prop) `MLTA_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define MLTA_ASSERT_CLK(lbl, clk, rst_n, prop)
`define MLTA_ASSERT(lbl, prop)
`endif
`endif

### sv/mlta_pkg.sv
// Shared types and constants of the MAC address table with aging.
// No dependencies; used by every module of the block except mlta_ram.
`default_nettype none
package mlta_pkg;
  localparam int unsigned MacW       = 48;
  localparam int unsigned PortW      = 4;
  localparam int unsigned AgeW       = 4;
  localparam int unsigned Buckets    = 256;
  localparam int unsigned BucketW    = $clog2(Buckets);
  localparam int unsigned WaysDefault = 4;
  localparam logic [AgeW-1:0] AgeReset = 4'd10;

  // register index decoded from paddr
  localparam logic RegAgeInitial = 1'b0;

  typedef enum logic [1:0] {
    VD_FLOOD  = 2'd0,
    VD_FWD    = 2'd1,
    VD_FILTER = 2'd2,
    VD_TICK   = 2'd3
  } verdict_e;

  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_TICK  = 1'b1
  } action_e;

  typedef struct packed {
    logic             action;
    logic [PortW-1:0] in_port;
    logic [MacW-1:0]  dst_mac;
    logic [MacW-1:0]  src_mac;
  } in_t;

  typedef struct packed {
    verdict_e         verdict;
    logic [PortW-1:0] out_port;
    logic             learn_dropped;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic               tick;
    logic [PortW-1:0]   port;
    logic [MacW-1:0]    dst_mac;
    logic [MacW-1:0]    src_mac;
    logic [BucketW-1:0] dst_bkt;
    logic [BucketW-1:0] src_bkt;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [MacW-1:0]  mac;
    logic [PortW-1:0] port;
    logic [AgeW-1:0]  age;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRC_RD,
    ST_SRC_UPD,
    ST_DST_CHK,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_TICK_DONE
  } state_e;
endpackage
`default_nettype wire

### sv/mac_learning_table_with_aging_unit.sv
// Frame: steps from acceptance to result are src read, update, dst read, verdict; the bucket
// RAM sequencer takes no new frame until the verdict of the current one has been issued.
// Tick: each of the 256 buckets is read and then written back aged, one bucket after another.
// After reset a clearing pass writes all 256 buckets; requests queue meanwhile.
// Reset is asynchronous, active low; age_initial resets to 10.
`default_nettype none
module mac_learning_table_with_aging_unit #(
  parameter int unsigned Ways = mlta_pkg::WaysDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic      [31:0]    prdata,
  output logic                pready,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire mlta_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mlta_pkg::out_t      out_data_o
);
  logic [mlta_pkg::AgeW-1:0] age_initial_q;
  logic                      cmd_valid, cmd_ready;
  mlta_pkg::cmd_t            cmd;

  assign pready = 1'b1;

  // config register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_initial_q <= mlta_pkg::AgeReset;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == mlta_pkg::RegAgeInitial)) begin
      age_initial_q <= pwdata[mlta_pkg::AgeW-1:0];
    end
  end

  // config register read
  assign prdata = (paddr[2] == mlta_pkg::RegAgeInitial)
                ? {{(32-mlta_pkg::AgeW){1'b0}}, age_initial_q} : '0;

  mlta_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  mlta_back #(
    .Ways(Ways)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .age_initial_i(age_initial_q),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (out_data_o)
  );
endmodule
`default_nettype wire

### sv/mlta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mlta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

### sv/mlta_front.sv
// Front end: accepts requests, classifies them and buffers them in a 2-deep queue.
// Depends on mlta_pkg.
`default_nettype none
module mlta_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mlta_pkg::in_t in_data_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output mlta_pkg::cmd_t     cmd_o
);
  mlta_pkg::cmd_t fifo_q [2];
  mlta_pkg::cmd_t cls;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  // classify: frame or tick, pick buckets from the low address byte
  always_comb begin
    cls.tick    = (in_data_i.action == mlta_pkg::ACT_TICK);
    cls.port    = in_data_i.in_port;
    cls.dst_mac = in_data_i.dst_mac;
    cls.src_mac = in_data_i.src_mac;
    cls.dst_bkt = in_data_i.dst_mac[mlta_pkg::BucketW-1:0];
    cls.src_bkt = in_data_i.src_mac[mlta_pkg::BucketW-1:0];
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### sv/mlta_back.sv
// Back end: sequencer over the bucket RAM doing learn, lookup, aging and clear.
// Depends on mlta_pkg, mlta_ram and the assertion macros header.
`default_nettype none
`include "mac_learning_table_with_aging_unit_macros.svh"
module mlta_back #(
  parameter int unsigned Ways = mlta_pkg::WaysDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  output logic                               cmd_ready_o,
  input  wire mlta_pkg::cmd_t                cmd_i,
  input  wire logic [mlta_pkg::AgeW-1:0]     age_initial_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output mlta_pkg::out_t                     res_o
);
  localparam int unsigned RowW = Ways * mlta_pkg::EntryW;

  mlta_pkg::state_e             state_q, state_d;
  mlta_pkg::cmd_t               cmd_q;
  logic [mlta_pkg::BucketW-1:0] cnt_q, cnt_d;
  logic [RowW-1:0]              row_new_q;
  logic                         drop_q, drop_d;
  mlta_pkg::out_t               res_q, res_d;
  logic                         res_valid_q, res_valid_d;

  logic                         we, re;
  logic [mlta_pkg::BucketW-1:0] waddr, raddr;
  logic [RowW-1:0]              wdata, rdata, upd_row, aged_row, lk_row;
  logic [mlta_pkg::AgeW-1:0]    load;
  logic                         slot_free;

  mlta_pkg::entry_t rd_ent [Ways];
  mlta_pkg::entry_t lk_ent [Ways];
  logic [Ways-1:0]  hit_vec, free_oh;
  logic             hit, any_free, found;
  logic [mlta_pkg::PortW-1:0] found_port;

  mlta_ram #(
    .Width(RowW),
    .Depth(mlta_pkg::Buckets)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign load      = (age_initial_i == '0) ? {{(mlta_pkg::AgeW-1){1'b0}}, 1'b1}
                                           : age_initial_i;
  assign slot_free = !res_valid_q || res_ready_i;
  // same bucket: take the row just written instead of the stale read
  assign lk_row    = (cmd_q.dst_bkt == cmd_q.src_bkt) ? row_new_q : rdata;

  // unpack rows into ways
  for (genvar w = 0; w < Ways; w++) begin : g_unpack
    assign rd_ent[w] = rdata[w*mlta_pkg::EntryW +: mlta_pkg::EntryW];
    assign lk_ent[w] = lk_row[w*mlta_pkg::EntryW +: mlta_pkg::EntryW];
  end

  // learn: find the source, else the lowest free way; build updated and aged rows
  always_comb begin
    logic             taken;
    mlta_pkg::entry_t e, a;
    taken    = 1'b0;
    hit_vec  = '0;
    free_oh  = '0;
    upd_row  = rdata;
    aged_row = rdata;
    for (int w = 0; w < Ways; w++) begin
      hit_vec[w] = rd_ent[w].valid && (rd_ent[w].mac == cmd_q.src_mac);
      if (!rd_ent[w].valid && !taken) begin
        free_oh[w] = 1'b1;
        taken      = 1'b1;
      end
    end
    hit      = |hit_vec;
    any_free = |free_oh;
    for (int w = 0; w < Ways; w++) begin
      e = rd_ent[w];
      if (hit_vec[w]) begin
        e.age = load;
      end else if (!hit && free_oh[w]) begin
        e.valid = 1'b1;
        e.mac   = cmd_q.src_mac;
        e.port  = cmd_q.port;
        e.age   = load;
      end
      upd_row[w*mlta_pkg::EntryW +: mlta_pkg::EntryW] = e;
      a = rd_ent[w];
      if (a.valid) begin
        if (a.age <= {{(mlta_pkg::AgeW-1){1'b0}}, 1'b1}) begin
          a.valid = 1'b0;
          a.age   = '0;
        end else begin
          a.age = a.age - {{(mlta_pkg::AgeW-1){1'b0}}, 1'b1};
        end
      end
      aged_row[w*mlta_pkg::EntryW +: mlta_pkg::EntryW] = a;
    end
  end

  // lookup: first matching way of the destination bucket
  always_comb begin
    found      = 1'b0;
    found_port = '0;
    for (int w = 0; w < Ways; w++) begin
      if (!found && lk_ent[w].valid && (lk_ent[w].mac == cmd_q.dst_mac)) begin
        found      = 1'b1;
        found_port = lk_ent[w].port;
      end
    end
  end

  // sequencer: next state, RAM control and result
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    cmd_ready_o = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = cmd_q.src_bkt;
    wdata       = upd_row;
    raddr       = cmd_q.src_bkt;
    case (state_q)
      mlta_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == mlta_pkg::BucketW'(mlta_pkg::Buckets - 1)) begin
          state_d = mlta_pkg::ST_IDLE;
        end
      end
      mlta_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cnt_d   = '0;
          state_d = cmd_i.tick ? mlta_pkg::ST_TICK_RD : mlta_pkg::ST_SRC_RD;
        end
      end
      mlta_pkg::ST_SRC_RD: begin
        re      = 1'b1;
        state_d = mlta_pkg::ST_SRC_UPD;
      end
      mlta_pkg::ST_SRC_UPD: begin
        we      = 1'b1;
        re      = 1'b1;
        raddr   = cmd_q.dst_bkt;
        drop_d  = !hit && !any_free;
        state_d = mlta_pkg::ST_DST_CHK;
      end
      mlta_pkg::ST_DST_CHK: begin
        if (slot_free) begin
          res_valid_d         = 1'b1;
          res_d.learn_dropped = drop_q;
          if (!found) begin
            res_d.verdict  = mlta_pkg::VD_FLOOD;
            res_d.out_port = '0;
          end else if (found_port == cmd_q.port) begin
            res_d.verdict  = mlta_pkg::VD_FILTER;
            res_d.out_port = '0;
          end else begin
            res_d.verdict  = mlta_pkg::VD_FWD;
            res_d.out_port = found_port;
          end
          state_d = mlta_pkg::ST_IDLE;
        end
      end
      mlta_pkg::ST_TICK_RD: begin
        re      = 1'b1;
        raddr   = cnt_q;
        state_d = mlta_pkg::ST_TICK_WR;
      end
      mlta_pkg::ST_TICK_WR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = aged_row;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == mlta_pkg::BucketW'(mlta_pkg::Buckets - 1)) begin
          state_d = mlta_pkg::ST_TICK_DONE;
        end else begin
          state_d = mlta_pkg::ST_TICK_RD;
        end
      end
      mlta_pkg::ST_TICK_DONE: begin
        if (slot_free) begin
          res_valid_d         = 1'b1;
          res_d.verdict       = mlta_pkg::VD_TICK;
          res_d.out_port      = '0;
          res_d.learn_dropped = 1'b0;
          state_d             = mlta_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mlta_pkg::ST_IDLE;
      end
    endcase
  end

  // hold state, counter and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlta_pkg::ST_CLEAR;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    if (state_q == mlta_pkg::ST_SRC_UPD) begin
      row_new_q <= upd_row;
    end
    drop_q <= drop_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `MLTA_ASSERT(a_tick_clean, res_valid_q && (res_q.verdict == mlta_pkg::VD_TICK) |-> (res_q.out_port == '0) && !res_q.learn_dropped)
  `MLTA_ASSERT(a_write_states, we |-> (state_q == mlta_pkg::ST_CLEAR) || (state_q == mlta_pkg::ST_SRC_UPD) || (state_q == mlta_pkg::ST_TICK_WR))
  `MLTA_ASSERT(a_pop_idle, cmd_valid_i && cmd_ready_o |-> state_q == mlta_pkg::ST_IDLE)
  `MLTA_ASSERT(a_res_source, $rose(res_valid_q) |-> ($past(state_q) == mlta_pkg::ST_DST_CHK) || ($past(state_q) == mlta_pkg::ST_TICK_DONE))
endmodule
`default_nettype wire
